// ===== src/hkm_pkg.sv =====
// shared types, codes and constants of the hotkey match table
package hkm_pkg;

  localparam int unsigned HKM_ENTRIES = 16;
  localparam logic [7:0]  HKM_MASK_RESET = 8'h07;

  // operation codes of an input item
  localparam logic [1:0] OP_REG    = 2'd0;
  localparam logic [1:0] OP_UNREG  = 2'd1;
  localparam logic [1:0] OP_KEY    = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // status codes of a result item
  localparam logic [1:0] STAT_ADDED    = 2'd0;
  localparam logic [1:0] STAT_REPLACED = 2'd1;
  localparam logic [1:0] STAT_NOMATCH  = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  key_code;
    logic [7:0]  modifiers;
    logic [15:0] handler_id;
    logic        key_down;
    logic        key_repeat;
    logic        handler_accepts;
  } in_t;

  typedef struct packed {
    logic        consumed;
    logic        fire;
    logic [15:0] fired_handler;
    logic [1:0]  status;
  } out_t;

  // one stored table entry
  typedef struct packed {
    logic [7:0]  key;
    logic [7:0]  mods;
    logic [15:0] handler;
    logic        held;
  } entry_t;

  localparam int unsigned HKM_ENTRY_W = $bits(entry_t);

endpackage

// ===== src/hkm_ram.sv =====
// generic simple dual-port ram with registered read data
module hkm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/hkm_match.sv =====
// entry compare unit: key plus either masked modifiers or the held mark
module hkm_match import hkm_pkg::*; (
  input  entry_t     entry_i,
  input  logic [7:0] key_i,
  input  logic [7:0] mods_i,
  input  logic       by_held_i,
  output logic       hit_o
);

  logic key_eq;
  logic mods_eq;

  assign key_eq  = (entry_i.key == key_i);
  assign mods_eq = (entry_i.mods == mods_i);
  assign hit_o   = key_eq && (by_held_i ? entry_i.held : mods_eq);

endmodule

// ===== src/hotkey_match_table_unit.sv =====
// top level of the hotkey match table: sequencer, entry storage and result register
// The table keeps up to ENTRIES hotkey entries in one ram, valid entries packed
// at the front in the order they were added, with a fill count marking the end.
// Every item is handled by walking the entries one at a time through a single
// compare unit: each entry visited takes a ram read, then a compare and act
// step. An unregister that removes an entry then moves each later entry down
// by one place, with a ram read and a ram write per entry, since the ram has
// a single read and a single write port. No item is taken while one is in
// work; a finished result waits in the output register, so the next item can
// start before the previous result is taken. The modifier mask is written
// through the configuration channel, which is always ready, and must only
// change while the table is idle.
module hotkey_match_table_unit import hkm_pkg::*; #(
  parameter int unsigned ENTRIES = HKM_ENTRIES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // item channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_data_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o,
  // configuration channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_RD    = 7'b0000010,
    ST_CMP   = 7'b0000100,
    ST_MISS  = 7'b0001000,
    ST_SH_RD = 7'b0010000,
    ST_SH_WR = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e        state_q, state_d;
  logic [7:0]    mask_q;
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] idx_q, idx_d;
  in_t           item_q, item_d;
  out_t          res_q, res_d;
  out_t          out_q, out_d;
  logic          out_valid_q, out_valid_d;

  // ram ports
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  entry_t        ram_rdata;

  logic          hit;
  logic          by_held;
  logic          more;      // another entry after idx
  logic          more_sh;   // another entry to move after idx+1
  logic          full;
  logic          out_free;

  hkm_ram #(
    .WIDTH (HKM_ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // release and repeat look up by held mark, the rest by masked modifiers
  assign by_held = (item_q.op == OP_KEY) && (!item_q.key_down || item_q.key_repeat);

  hkm_match u_match (
    .entry_i   (ram_rdata),
    .key_i     (item_q.key_code),
    .mods_i    (item_q.modifiers),
    .by_held_i (by_held),
    .hit_o     (hit)
  );

  assign more     = ((CW + 1)'(idx_q) + (CW + 1)'(1)) < (CW + 1)'(count_q);
  assign more_sh  = ((CW + 1)'(idx_q) + (CW + 1)'(2)) < (CW + 1)'(count_q);
  assign full     = (count_q == CW'(ENTRIES));
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    item_d    = item_q;
    res_d     = res_q;
    out_d     = out_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = idx_q;

    // result register drains on a transfer
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d           = in_data_i;
          item_d.modifiers = in_data_i.modifiers & mask_q;
          idx_d            = '0;
          res_d            = '0;
          res_d.status     = STAT_NOMATCH;
          // empty table or unused op goes straight to the miss handling
          if (count_q == '0 || in_data_i.op == OP_UNUSED) begin
            state_d = ST_MISS;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        ram_re  = 1'b1;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (hit) begin
          state_d = ST_DONE;
          case (item_q.op)
            OP_REG: begin
              ram_we            = 1'b1;
              ram_wdata.handler = item_q.handler_id;
              res_d.status      = STAT_REPLACED;
            end
            OP_UNREG: begin
              res_d.consumed = 1'b1;
              res_d.status   = STAT_ADDED;
              if (more) begin
                state_d = ST_SH_RD;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            default: begin
              res_d.status = STAT_ADDED;
              if (!item_q.key_down) begin
                // release clears the held mark
                ram_we         = 1'b1;
                ram_wdata.held = 1'b0;
                res_d.consumed = 1'b1;
              end else if (item_q.key_repeat) begin
                res_d.consumed = 1'b1;
              end else begin
                // fresh press fires, the handler's answer sets held
                ram_we              = 1'b1;
                ram_wdata.held      = item_q.handler_accepts;
                res_d.fire          = 1'b1;
                res_d.fired_handler = ram_rdata.handler;
                res_d.consumed      = item_q.handler_accepts;
              end
            end
          endcase
        end else if (more) begin
          idx_d   = idx_q + IW'(1);
          state_d = ST_RD;
        end else begin
          state_d = ST_MISS;
        end
      end
      ST_MISS: begin
        state_d = ST_DONE;
        if (item_q.op == OP_REG) begin
          if (full) begin
            res_d.status = STAT_FULL;
          end else begin
            // append at the end of the packed prefix
            ram_we            = 1'b1;
            ram_waddr         = IW'(count_q);
            ram_wdata.key     = item_q.key_code;
            ram_wdata.mods    = item_q.modifiers;
            ram_wdata.handler = item_q.handler_id;
            ram_wdata.held    = 1'b0;
            count_d           = count_q + CW'(1);
            res_d.status      = STAT_ADDED;
          end
        end
      end
      ST_SH_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_q + IW'(1);
        state_d   = ST_SH_WR;
      end
      ST_SH_WR: begin
        // move the later entry down one place
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = ram_rdata;
        idx_d     = idx_q + IW'(1);
        if (more_sh) begin
          state_d = ST_SH_RD;
        end else begin
          count_d = count_q - CW'(1);
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      mask_q      <= HKM_MASK_RESET;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        mask_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // fill count stays within the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ENTRIES))
    else $error("entry count beyond table size");

  // the count moves by at most one per item step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + CW'(1) || count_q == $past(count_q) - CW'(1)))
    else $error("entry count jumped");

  // ram writes only come from compare, miss or move steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CMP || state_q == ST_MISS || state_q == ST_SH_WR))
    else $error("ram write outside a write step");

  // a fired handler always reports a match
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.fire) |-> out_data_o.status == STAT_ADDED)
    else $error("fire with non-match status");

  // a handler id is only reported when a handler fires
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.fire) |-> out_data_o.fired_handler == '0)
    else $error("handler id without fire");

endmodule
